### hdl/periodic_history_ring_store_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the periodic history ring store
// Shared checks on clk with the asynchronous active-low reset rst_n.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_HISTORY_RING_STORE_DEFINES_SVH
`define PERIODIC_HISTORY_RING_STORE_DEFINES_SVH

// same-cycle implication
`define PHRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PHRS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/phrs_pkg.sv
// ----------------------------------------------------------------------------
// phrs_pkg
// Beat types, opcodes, status codes and register indexes of the ring store.
// ----------------------------------------------------------------------------
package phrs_pkg;

    localparam int IDX_W = 13;

    localparam logic [2:0] OP_CAPTURE = 3'd0;
    localparam logic [2:0] OP_GET     = 3'd1;
    localparam logic [2:0] OP_SYNC    = 3'd2;
    localparam logic [2:0] OP_CLEAR   = 3'd3;
    localparam logic [2:0] OP_EXPORT  = 3'd4;
    localparam logic [2:0] OP_COUNT   = 3'd5;
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_IGNORED   = 2'd2;

    localparam logic [1:0] REG_ENABLE   = 2'd0;
    localparam logic [1:0] REG_INTERVAL = 2'd1;
    localparam logic [1:0] REG_CAPACITY = 2'd2;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [63:0]      record_data;
        logic [31:0]      capture_time;
        logic             capture_time_synced;
        logic [31:0]      sync_unix_time;
        logic [31:0]      uptime_seconds;
        logic [IDX_W-1:0] record_index;
        logic [31:0]      window_from;
        logic [31:0]      window_to;
        logic [7:0]       page_limit;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             is_record;
        logic [63:0]      out_data;
        logic [31:0]      record_time;
        logic             stamp_unix;
        logic [IDX_W-1:0] next_ordinal;
        logic [IDX_W-1:0] tally;
        logic             last;
    } out_item_t;

endpackage

### hdl/phrs_ram.sv
// ----------------------------------------------------------------------------
// phrs_ram
// Single-port RAM with registered read, read enable and write enable.
// ----------------------------------------------------------------------------
module phrs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                         wdata,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

### hdl/periodic_history_ring_store.sv
// ----------------------------------------------------------------------------
// periodic_history_ring_store
// Capture, sync and clear pass from dispatch to result; get adds a RAM read
// wait; export walks stored ordinals, skipping those before the window and
// emitting each record read; count walks ordinals (none at page size zero).
// One item at a time through one sequencer, which an output stall holds.
// Reset clears all control state and registers; record memory is not cleared.
// ----------------------------------------------------------------------------
`include "periodic_history_ring_store_defines.svh"

module periodic_history_ring_store #(
    parameter int DEPTH        = 4096,
    parameter int RECORD_BITS  = 64,
    parameter int PAGE_RECORDS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  phrs_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output phrs_pkg::out_item_t  out_item,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_wdata
);

    localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int IW = phrs_pkg::IDX_W;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_GET_WAIT, S_EXP_INIT, S_EXP_WALK,
        S_EXP_DATA, S_EXP_OUT, S_CNT_WALK, S_RESULT
    } state_t;

    state_t              state_reg, state_next;
    phrs_pkg::in_item_t  item_reg, item_next;
    logic [AW-1:0]       oldest_reg, oldest_next;
    logic [IW-1:0]       count_reg, count_next;
    logic [31:0]         base_reg, base_next;
    logic                synced_reg, synced_next;
    logic [31:0]         rint_reg, rint_next;
    logic                en_reg, en_next;
    logic [31:0]         intv_reg, intv_next;
    logic [IW-1:0]       cap_reg, cap_next;
    logic [IW-1:0]       ord_reg, ord_next;
    logic [31:0]         t_reg, t_next;
    logic [31:0]         prod_reg, prod_next;
    logic [IW-1:0]       written_reg, written_next;
    logic [31:0]         t0_reg, t0_next;
    logic [7:0]          in_page_reg, in_page_next;
    logic [IW-1:0]       pages_reg, pages_next;
    phrs_pkg::out_item_t res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    phrs_pkg::out_item_t out_item_reg, out_item_next;

    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_addr;
    logic [RECORD_BITS-1:0] ram_q;

    logic [AW-1:0] s_oldest;
    logic [IW-1:0] s_ord;
    logic [31:0]   s_sum;
    logic [AW-1:0] slot;
    logic [7:0]    per_page;
    logic          w_stop, w_skip;
    logic          out_free;
    logic          ivl_changed;
    logic [IW-1:0] eff_count;
    logic [IW-1:0] cap_wr;
    logic [31:0]   oldest_inc;

    assign out_free = !out_valid_reg || out_ready;
    assign per_page = (item_reg.page_limit < 8'(PAGE_RECORDS))
                      ? item_reg.page_limit : 8'(PAGE_RECORDS);
    // window test is bypassed while the base is not unix time
    assign w_stop = synced_reg && (t_reg > item_reg.window_to);
    assign w_skip = synced_reg && !w_stop && (t_reg < item_reg.window_from);

    assign ivl_changed = rint_reg != intv_reg;
    assign eff_count   = ivl_changed ? '0 : count_reg;
    assign oldest_inc  = 32'(oldest_reg) + 32'd1;
    assign cap_wr      = (32'(cfg_wdata[IW-1:0]) > 32'(DEPTH))
                         ? IW'(DEPTH) : cfg_wdata[IW-1:0];

    // ring slot of an ordinal: sum stays below twice the capacity
    always_comb
    begin
        s_sum = 32'(s_oldest) + 32'(s_ord);
        if (s_sum >= 32'(cap_reg))
        begin
            s_sum = s_sum - 32'(cap_reg);
        end
        slot = AW'(s_sum);
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        oldest_next    = oldest_reg;
        count_next     = count_reg;
        base_next      = base_reg;
        synced_next    = synced_reg;
        rint_next      = rint_reg;
        en_next        = en_reg;
        intv_next      = intv_reg;
        cap_next       = cap_reg;
        ord_next       = ord_reg;
        t_next         = t_reg;
        prod_next      = prod_reg;
        written_next   = written_reg;
        t0_next        = t0_reg;
        in_page_next   = in_page_reg;
        pages_next     = pages_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_addr       = slot;
        s_oldest       = oldest_reg;
        s_ord          = ord_reg;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                phrs_pkg::REG_ENABLE:   en_next = cfg_wdata[0];
                phrs_pkg::REG_INTERVAL: intv_next = cfg_wdata;
                phrs_pkg::REG_CAPACITY:
                begin
                    if (cap_wr != cap_reg)
                    begin
                        oldest_next = '0;
                        count_next  = '0;
                        base_next   = '0;
                        synced_next = 1'b0;
                    end
                    cap_next = cap_wr;
                end
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next  = in_item;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                res_next      = '0;
                res_next.last = 1'b1;
                state_next    = S_RESULT;
                unique case (item_reg.opcode)
                    phrs_pkg::OP_CAPTURE:
                    begin
                        if (!en_reg || cap_reg == '0)
                        begin
                            res_next.status = phrs_pkg::ST_IGNORED;
                        end
                        else
                        begin
                            rint_next = intv_reg;
                            ram_we    = 1'b1;
                            if (eff_count < cap_reg)
                            begin
                                s_oldest    = ivl_changed ? '0 : oldest_reg;
                                s_ord       = eff_count;
                                oldest_next = s_oldest;
                                count_next  = eff_count + 1'b1;
                                if (eff_count == '0)
                                begin
                                    base_next   = item_reg.capture_time;
                                    synced_next = item_reg.capture_time_synced;
                                end
                            end
                            else
                            begin
                                s_ord       = '0;
                                base_next   = base_reg + rint_reg;
                                oldest_next = (oldest_inc >= 32'(cap_reg))
                                              ? '0 : AW'(oldest_inc);
                            end
                        end
                    end
                    phrs_pkg::OP_GET:
                    begin
                        if (item_reg.record_index >= count_reg)
                        begin
                            res_next.status = phrs_pkg::ST_NOT_FOUND;
                        end
                        else
                        begin
                            s_ord      = item_reg.record_index;
                            ram_re     = 1'b1;
                            prod_next  = 32'(32'(item_reg.record_index) * rint_reg);
                            state_next = S_GET_WAIT;
                        end
                    end
                    phrs_pkg::OP_SYNC:
                    begin
                        if (!synced_reg && count_reg != '0)
                        begin
                            base_next = base_reg + (item_reg.sync_unix_time
                                                    - item_reg.uptime_seconds);
                        end
                        synced_next         = 1'b1;
                        res_next.stamp_unix = 1'b1;
                    end
                    phrs_pkg::OP_CLEAR:
                    begin
                        oldest_next = '0;
                        count_next  = '0;
                        base_next   = '0;
                        synced_next = 1'b0;
                    end
                    phrs_pkg::OP_EXPORT:
                    begin
                        prod_next    = 32'(32'(item_reg.record_index) * rint_reg);
                        ord_next     = item_reg.record_index;
                        written_next = '0;
                        t0_next      = '0;
                        state_next   = S_EXP_INIT;
                    end
                    phrs_pkg::OP_COUNT:
                    begin
                        ord_next     = '0;
                        t_next       = base_reg;
                        pages_next   = '0;
                        in_page_next = '0;
                        if (per_page != '0)
                        begin
                            state_next = S_CNT_WALK;
                        end
                    end
                    default: ;
                endcase
            end

            S_GET_WAIT:
            begin
                res_next             = '0;
                res_next.is_record   = 1'b1;
                res_next.out_data    = 64'(ram_q);
                res_next.record_time = base_reg + prod_reg;
                res_next.stamp_unix  = synced_reg;
                res_next.last        = 1'b1;
                state_next           = S_RESULT;
            end

            S_EXP_INIT:
            begin
                t_next     = base_reg + prod_reg;
                state_next = S_EXP_WALK;
            end

            S_EXP_WALK:
            begin
                if (ord_reg >= count_reg || w_stop
                    || (!w_skip && 32'(written_reg) >= 32'(per_page)))
                begin
                    res_next              = '0;
                    res_next.record_time  = t0_reg;
                    res_next.stamp_unix   = synced_reg;
                    res_next.next_ordinal = ord_reg;
                    res_next.tally        = written_reg;
                    res_next.last         = 1'b1;
                    state_next            = S_RESULT;
                end
                else if (w_skip)
                begin
                    ord_next = ord_reg + 1'b1;
                    t_next   = t_reg + rint_reg;
                end
                else
                begin
                    ram_re = 1'b1;
                    if (written_reg == '0)
                    begin
                        t0_next = t_reg;
                    end
                    state_next = S_EXP_DATA;
                end
            end

            S_EXP_DATA:
            begin
                res_next             = '0;
                res_next.is_record   = 1'b1;
                res_next.out_data    = 64'(ram_q);
                res_next.record_time = t_reg;
                res_next.stamp_unix  = synced_reg;
                state_next           = S_EXP_OUT;
            end

            S_EXP_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = res_reg;
                    written_next   = written_reg + 1'b1;
                    ord_next       = ord_reg + 1'b1;
                    t_next         = t_reg + rint_reg;
                    state_next     = S_EXP_WALK;
                end
            end

            S_CNT_WALK:
            begin
                if (ord_reg >= count_reg || w_stop)
                begin
                    res_next       = '0;
                    res_next.tally = pages_reg;
                    res_next.last  = 1'b1;
                    state_next     = S_RESULT;
                end
                else
                begin
                    // a match opening a fresh page adds one page
                    if (!w_skip)
                    begin
                        if (in_page_reg == '0)
                        begin
                            pages_next = pages_reg + 1'b1;
                        end
                        in_page_next = (in_page_reg + 8'd1 == per_page)
                                       ? '0 : in_page_reg + 8'd1;
                    end
                    ord_next = ord_reg + 1'b1;
                    t_next   = t_reg + rint_reg;
                end
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            oldest_reg    <= '0;
            count_reg     <= '0;
            base_reg      <= '0;
            synced_reg    <= 1'b0;
            rint_reg      <= '0;
            en_reg        <= 1'b0;
            intv_reg      <= 32'd300;
            cap_reg       <= IW'(DEPTH);
            ord_reg       <= '0;
            t_reg         <= '0;
            prod_reg      <= '0;
            written_reg   <= '0;
            t0_reg        <= '0;
            in_page_reg   <= '0;
            pages_reg     <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            base_reg      <= base_next;
            synced_reg    <= synced_next;
            rint_reg      <= rint_next;
            en_reg        <= en_next;
            intv_reg      <= intv_next;
            cap_reg       <= cap_next;
            ord_reg       <= ord_next;
            t_reg         <= t_next;
            prod_reg      <= prod_next;
            written_reg   <= written_next;
            t0_reg        <= t0_next;
            in_page_reg   <= in_page_next;
            pages_reg     <= pages_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

    phrs_ram #(
        .WIDTH (RECORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (item_reg.record_data[RECORD_BITS-1:0]),
        .rdata (ram_q)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `PHRS_ASSERT_IMP(a_count_le_cap, 1'b1, count_reg <= cap_reg, "count above capacity")
    `PHRS_ASSERT_IMP(a_oldest_in_ring, count_reg != '0, 32'(oldest_reg) < 32'(cap_reg), "oldest slot outside ring")
    `PHRS_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")

endmodule
